// ===== hw/rtl/wdra_pkg.sv =====
`default_nettype none

package wdra_pkg;

  localparam int WINDOW_SLOTS_DEF = 4;
  localparam int GAP_CLAMP        = 3;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 64;
  localparam int DELTA_W = 32;
  localparam int AVG_W   = 32;
  localparam int TDATA_W = TIME_W + VALUE_W;

  // item kinds carried on s_tuser
  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic capture;
    logic eval;
    logic push;
    logic sum;
    logic prep;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic fill_ok;
    logic count_pos;
    logic zeros_done;
    logic sum_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wdra_ctrl.sv =====
`default_nettype none

module wdra_ctrl
  import wdra_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_PUSH = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   prep;
  logic   prep_next;

  always_comb begin
    state_next = state;
    prep_next  = 1'b0;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.is_read) begin
          state_next = sts.count_pos ? ST_SUM : ST_DONE;
        end else begin
          state_next = sts.fill_ok ? ST_PUSH : ST_IDLE;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (sts.zeros_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_last) begin
          prep_next  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        // first cycle loads the dividend magnitude
        if (prep) begin
          cmd.prep = 1'b1;
        end else begin
          cmd.div = 1'b1;
          if (sts.div_last) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prep  <= 1'b0;
    end else begin
      state <= state_next;
      prep  <= prep_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wdra_dpath.sv =====
`default_nettype none

module wdra_dpath
  import wdra_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  wire                 kind,
  input  wire  [TIME_W-1:0]   now,
  input  wire  [DELTA_W-1:0]  value_lo,
  input  wire                 m_tready,
  output logic                m_tvalid,
  output logic [AVG_W-1:0]    average
);

  localparam int PTR_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
  localparam int SUM_W  = DELTA_W + $clog2(WINDOW_SLOTS) + 1;
  localparam int BCNT_W = $clog2(SUM_W);
  localparam int ZC_W   = $clog2(GAP_CLAMP);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W:0]   SLOTS_P1 = (CNT_W + 1)'(WINDOW_SLOTS + 1);

  logic                kind_r;
  logic [TIME_W-1:0]   now_r;
  logic [DELTA_W-1:0]  value_r;

  logic [TIME_W-1:0]   last_time;
  logic [DELTA_W-1:0]  last_sample;
  logic [DELTA_W-1:0]  delta_ring [WINDOW_SLOTS];
  logic [PTR_W-1:0]    ring_pointer;
  logic [DELTA_W-1:0]  delta_r;
  logic [ZC_W-1:0]     zcnt;

  logic [PTR_W-1:0]    rd;
  logic [CNT_W-1:0]    left;
  logic [CNT_W-1:0]    cnt;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [BCNT_W-1:0]   bcnt;
  logic                neg;

  logic signed [TIME_W-1:0] diff;
  logic [CNT_W-1:0]         count;
  logic [ZC_W-1:0]          zeros;
  logic [CNT_W:0]           trial;
  logic                     ge;
  logic [PTR_W-1:0]         ptr_dec;
  logic [DELTA_W-1:0]       rd_word;

  assign diff = $signed(now_r - last_time);

  always_comb begin
    if (diff < $signed(TIME_W'(2))) begin
      count = CNT_W'(WINDOW_SLOTS);
    end else begin
      count = CNT_W'(SLOTS_P1 - diff[CNT_W:0]);
    end
    if (diff >= $signed(TIME_W'(GAP_CLAMP))) begin
      zeros = ZC_W'(GAP_CLAMP - 1);
    end else begin
      zeros = ZC_W'(diff[ZC_W-1:0] - ZC_W'(1));
    end
  end

  assign ptr_dec = (ring_pointer == '0) ? PTR_LAST : ring_pointer - PTR_W'(1);
  assign rd_word = delta_ring[rd];

  assign trial = {rem, quo[SUM_W-1]};
  assign ge    = (trial >= {1'b0, cnt});

  assign sts.is_read    = (kind_r == KIND_READ);
  assign sts.fill_ok    = (diff > $signed(TIME_W'(0)));
  assign sts.count_pos  = (diff <= $signed(TIME_W'(WINDOW_SLOTS)));
  assign sts.zeros_done = (zcnt == '0);
  assign sts.sum_last   = (left == CNT_W'(1));
  assign sts.div_last   = (bcnt == '0);
  assign sts.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind;
      now_r   <= now;
      value_r <= value_lo;
    end
    if (cmd.eval) begin
      delta_r <= value_r - last_sample;
      zcnt    <= zeros;
      rd      <= ptr_dec;
      left    <= count;
      cnt     <= count;
      acc     <= '0;
      quo     <= '0;
      neg     <= 1'b0;
    end
    if (cmd.push && zcnt != '0) begin
      zcnt <= zcnt - ZC_W'(1);
    end
    if (cmd.sum) begin
      acc  <= acc + {{(SUM_W - DELTA_W){rd_word[DELTA_W-1]}}, rd_word};
      rd   <= (rd == '0) ? PTR_LAST : rd - PTR_W'(1);
      left <= left - CNT_W'(1);
    end
    if (cmd.prep) begin
      neg  <= acc[SUM_W-1];
      quo  <= acc[SUM_W-1] ? SUM_W'(-acc) : acc;
      rem  <= '0;
      bcnt <= BCNT_W'(SUM_W - 1);
    end
    if (cmd.div) begin
      rem  <= ge ? CNT_W'(trial - {1'b0, cnt}) : CNT_W'(trial);
      quo  <= {quo[SUM_W-2:0], ge};
      bcnt <= bcnt - BCNT_W'(1);
    end
    if (cmd.out_load) begin
      average <= neg ? AVG_W'(-quo[AVG_W-1:0]) : quo[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time    <= '0;
      last_sample  <= '0;
      ring_pointer <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        delta_ring[i] <= '0;
      end
    end else begin
      if (cmd.eval && !sts.is_read && sts.fill_ok) begin
        last_time   <= now_r;
        last_sample <= value_r;
      end
      if (cmd.push) begin
        delta_ring[ring_pointer] <= (zcnt != '0) ? '0 : delta_r;
        ring_pointer <= (ring_pointer == PTR_LAST) ? '0 : ring_pointer + PTR_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_delta_rate_averager.sv =====
// Windowed delta rate averager.
// Slave channel s_*: one beat per item. s_tuser is the kind (0 = fill,
// 1 = read); s_tdata carries now (signed time in ticks) and value (signed
// 64-bit counter sample, used by fills only).
// A fill later than the last fill stores the counter delta in a ring of
// WINDOW_SLOTS slots, after up to two zero slots for skipped ticks. A read
// returns one beat on m_* with the truncated average of the newest slots
// still inside the window, or 0 when none are.
// One item is worked at a time; s_tready is high only while idle.
// Fill: 1 to 3 ring writes (one per cycle) if not stale. Read: sums the
// N newest slots, N = slots averaged (1..WINDOW_SLOTS), then divides the sum
// by N bit-serially over SUM_W = 32 + clog2(WINDOW_SLOTS) + 1 bits (35 at 4
// slots); a read whose window is empty skips both. The divider sets the read time.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, a following read finishes and holds until
// the register frees up.
// Reset (synchronous) clears the ring, pointer, last time, last sample and m_tvalid.
`default_nettype none

module windowed_delta_rate_averager
  import wdra_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire  [TDATA_W-1:0] s_tdata,   // [31:0] now, [95:32] value
  input  wire  [0:0]         s_tuser,   // [0] kind
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [AVG_W-1:0]   m_tdata    // [31:0] average
);

  cmd_t cmd;
  sts_t sts;

  wdra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wdra_dpath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .kind     (s_tuser[0]),
    .now      (s_tdata[TIME_W-1:0]),
    .value_lo (s_tdata[TIME_W+DELTA_W-1:TIME_W]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .average  (m_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous one in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");

  a_fill_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] == KIND_FILL) |=> !cmd.out_load ##1 !cmd.out_load)
    else $error("fill produced a result");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench
  import wdra_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int HOLD_LEN       = 200;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;   // [31:0] now, [95:32] value
  logic [0:0]         s_tuser;   // [0] kind
  logic               m_tvalid;
  logic               m_tready;
  logic [AVG_W-1:0]   m_tdata;   // [31:0] average

  // predicted block state
  logic [TIME_W-1:0]         tick_last = '0;
  logic [VALUE_W-1:0]        count_last = '0;
  logic signed [DELTA_W-1:0] delta_slot [WINDOW_SLOTS_DEF] = '{default: '0};
  int                        slot_ptr = 0;

  logic [AVG_W-1:0] avg_expected [$];

  int err_count    = 0;
  int hold_cycles  = 0;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  windowed_delta_rate_averager DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [AVG_W-1:0] got,
                                 input logic [AVG_W-1:0] want);
    err_count++;
    $display("mismatch: %s got %h want %h", what, got, want);
  endtask

  // Update predicted state for one accepted item; queue the average for reads.
  task automatic predict_item(input logic kind, input logic [TIME_W-1:0] now_t,
                              input logic [VALUE_W-1:0] val);
    logic signed [TIME_W-1:0]  diff;
    logic [DELTA_W-1:0]        delta;
    int                        gap;
    longint                    extra;
    longint                    cnt;
    longint                    total;
    diff = now_t - tick_last;
    if (kind == KIND_FILL) begin
      if (diff > 0) begin
        delta      = DELTA_W'(val - count_last);
        tick_last  = now_t;
        count_last = val;
        gap = (diff < GAP_CLAMP) ? int'(diff) : GAP_CLAMP;
        // skipped ticks get zero slots ahead of the delta
        for (int i = 1; i <= gap; i++) begin
          delta_slot[slot_ptr] = (i == gap) ? delta : '0;
          slot_ptr = (slot_ptr + 1) % WINDOW_SLOTS_DEF;
        end
      end
    end else begin
      extra = longint'(diff) - 1;
      if (extra < 0) extra = 0;
      cnt   = WINDOW_SLOTS_DEF - extra;
      total = 0;
      if (cnt > 0) begin
        for (int i = 0; i < cnt; i++)
          total += longint'(delta_slot[(slot_ptr + WINDOW_SLOTS_DEF - 1 - i) % WINDOW_SLOTS_DEF]);
        total = total / cnt;
      end
      avg_expected.push_back(total[AVG_W-1:0]);
    end
  endtask

  task automatic send_item(input logic kind, input logic [TIME_W-1:0] now_t,
                           input logic [VALUE_W-1:0] val);
    int gap_len;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap_len = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, now_t};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    predict_item(kind, now_t, val);
  endtask

  task automatic test_directed();
    logic [TIME_W-1:0]  t;
    logic [VALUE_W-1:0] v;
    send_item(KIND_READ, 32'd0, 64'd0);
    send_item(KIND_FILL, 32'd1, 64'd100);
    send_item(KIND_FILL, 32'd2, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(KIND_FILL, 32'd2, 64'd5);                    // stale, same time
    send_item(KIND_FILL, 32'd1, 64'd7);                    // stale, earlier time
    send_item(KIND_FILL, 32'd4, 64'h8000_0000_0000_0000);  // one skipped tick, 64-bit wrap
    send_item(KIND_FILL, 32'd100, 64'h8000_0000_7FFF_FFFF); // gap clamped
    send_item(KIND_READ, 32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_READ, 32'd102, 64'd0);
    send_item(KIND_READ, 32'd104, 64'd0);
    send_item(KIND_READ, 32'd105, 64'd0);                  // empty window
    send_item(KIND_READ, 32'd1000, 64'd0);
    send_item(KIND_READ, 32'd99, 64'd0);
    send_item(KIND_READ, 32'h8000_0064, 64'd0);            // most negative difference
    send_item(KIND_FILL, 32'h7FFF_FFFF, 64'd0);
    send_item(KIND_FILL, 32'h8000_0000, 64'd0);            // time wraps, diff 1
    t = 32'h8000_0000;
    v = 64'd0;
    for (int i = 0; i < 4; i++) begin
      t++;
      v += 64'h7FFF_FFFF;
      send_item(KIND_FILL, t, v);
    end
    send_item(KIND_READ, t, 64'd0);
    for (int i = 0; i < 4; i++) begin
      t++;
      v += 64'h8000_0000;
      send_item(KIND_FILL, t, v);
    end
    send_item(KIND_READ, t, 64'd0);
  endtask

  task automatic test_random_traffic(input int n);
    int                 r;
    logic               kind;
    logic [TIME_W-1:0]  now_t;
    logic [VALUE_W-1:0] val;
    logic [31:0]        d;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      val = {$urandom, $urandom};
      if (r < 12) begin
        kind  = 1'($urandom_range(0, 1));
        now_t = $urandom;
      end else if (r < 20) begin
        kind  = KIND_FILL;
        now_t = tick_last - TIME_W'($urandom_range(0, 4));
      end else if (r < 62) begin
        kind = KIND_FILL;
        if ($urandom_range(0, 9) == 0)
          now_t = tick_last + TIME_W'($urandom_range(4, 100000));
        else
          now_t = tick_last + TIME_W'($urandom_range(1, 3));
        d = $urandom;
        case ($urandom_range(0, 3))
          0, 1: val = count_last + VALUE_W'($urandom_range(0, 5000));
          2:    val = count_last + {{32{d[31]}}, d};
          default: ;
        endcase
      end else begin
        kind = KIND_READ;
        if ($urandom_range(0, 9) == 0)
          now_t = $urandom;
        else
          now_t = tick_last + TIME_W'($urandom_range(0, 6));
      end
      send_item(kind, now_t, val);
    end
  endtask

  // Sink stalls for a long stretch while reads keep coming.
  task automatic test_output_stall();
    hold_cycles = HOLD_LEN;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0)
        send_item(KIND_FILL, tick_last + 32'd1, count_last + VALUE_W'($urandom_range(0, 999)));
      else
        send_item(KIND_READ, tick_last + TIME_W'($urandom_range(0, 3)), {$urandom, $urandom});
    end
  endtask

  task automatic test_drain_pause();
    test_random_traffic(40);
    s_tvalid <= 1'b0;
    wait (avg_expected.size() == 0);
    @(posedge clk);
    test_random_traffic(40);
  endtask

  task automatic test_full_rate(input int n);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(n);
  endtask

  // sink side
  initial begin
    int burst;
    burst = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (burst > 0) begin
        m_tready <= 1'b0;
        burst--;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        burst = $urandom_range(0, 10);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    logic [AVG_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (avg_expected.size() == 0) begin
          report_mismatch("average beat with nothing pending", m_tdata, '0);
        end else begin
          want = avg_expected.pop_front();
          if (m_tdata !== want) report_mismatch("average", m_tdata, want);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[windowed_delta_rate_averager] ERROR");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(700);
    test_output_stall();
    test_drain_pause();
    test_full_rate(780);
    s_tvalid <= 1'b0;
    wait (avg_expected.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[windowed_delta_rate_averager] OK");
    end else begin
      $display("[windowed_delta_rate_averager] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
